### hdl/gpu_pkg.sv
package gpu_pkg;

	localparam int COORD_WIDTH_DEF = 24;

	typedef enum logic [2:0] {
		REQ_AHEAD          = 3'd0,
		REQ_LEFT_OR_AHEAD  = 3'd1,
		REQ_RIGHT_OR_AHEAD = 3'd2,
		REQ_RIGHT_OF       = 3'd3,
		REQ_ON_SEGMENT     = 3'd4,
		REQ_IN_CIRCLE      = 3'd5
	} req_type_t;

endpackage

### hdl/gpu_wide_mul.sv
module gpu_wide_mul import gpu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic        [2*COORD_WIDTH:0]     a,
	input  logic signed [2*COORD_WIDTH+1:0]   b,
	output logic signed [4*COORD_WIDTH+2:0]   p
);

	localparam int W  = COORD_WIDTH;
	localparam int H  = W + 1;
	localparam int PW = 4*W + 3;

	logic        [H-1:0]   a_lo;
	logic        [W-1:0]   a_hi;
	logic        [H-1:0]   b_lo;
	logic signed [H-1:0]   b_hi;

	logic        [2*H-1:0] ll_s1;
	logic signed [2*H:0]   lh_s1;
	logic        [2*W:0]   hl_s1;
	logic signed [2*H-1:0] hh_s1;

	logic signed [PW-1:0]  ll_e;
	logic signed [PW-1:0]  mid_e;
	logic signed [PW-1:0]  hh_e;
	logic signed [PW-1:0]  prod_s2;

	assign a_lo = a[H-1:0];
	assign a_hi = a[2*W:H];
	assign b_lo = b[H-1:0];
	assign b_hi = b[2*W+1:H];

	// split halves, partial products registered before the final sum
	always_ff @(posedge clk) begin
		ll_s1 <= a_lo * b_lo;
		lh_s1 <= $signed({1'b0, a_lo}) * b_hi;
		hl_s1 <= a_hi * b_lo;
		hh_s1 <= $signed({1'b0, a_hi}) * b_hi;
	end

	assign ll_e  = $signed({{(PW-2*H){1'b0}}, ll_s1});
	assign mid_e = ($signed({{(PW-2*H-1){lh_s1[2*H]}}, lh_s1})
		+ $signed({{(PW-2*W-1){1'b0}}, hl_s1})) <<< H;
	assign hh_e  = $signed({{(PW-2*H){hh_s1[2*H-1]}}, hh_s1}) <<< (2*H);

	always_ff @(posedge clk) begin
		prod_s2 <= hh_e + mid_e + ll_e;
	end

	assign p = prod_s2;

endmodule

### hdl/geometric_predicate_unit.sv
// Geometric predicate unit: exact orientation, dot-product and in-circle tests.
//
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low. busy is held low: the pipeline takes one request every
// cycle, back to back, with no gaps needed.
// Each request carries req_type and points P, Q, R, S (signed COORD_WIDTH-bit
// coordinates); unused points are ignored.
//
// Result channel: done is high for exactly one cycle, with verdict valid
// alongside it. Results leave in request order, one per request, at one
// per cycle. A seven-stage pipeline computes them: differences, products,
// sums, two stages of split wide multiplies for the in-circle determinant,
// the determinant sum and the final select.
// The receiver cannot stall: each result must be taken in its cycle.
//
// Reset (arst_n low) clears all stage valid bits; requests in flight are
// dropped and no done pulse follows. Selectors 6 and 7 give verdict 0.
module geometric_predicate_unit import gpu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    req_type,
	input  logic signed [COORD_WIDTH-1:0] p_x,
	input  logic signed [COORD_WIDTH-1:0] p_y,
	input  logic signed [COORD_WIDTH-1:0] q_x,
	input  logic signed [COORD_WIDTH-1:0] q_y,
	input  logic signed [COORD_WIDTH-1:0] r_x,
	input  logic signed [COORD_WIDTH-1:0] r_y,
	input  logic signed [COORD_WIDTH-1:0] s_x,
	input  logic signed [COORD_WIDTH-1:0] s_y,
	output logic                          done,
	output logic                          verdict
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int MW   = 2*DW;
	localparam int SW   = 2*DW + 1;
	localparam int AW   = 2*W + 1;
	localparam int PW   = 4*W + 3;
	localparam int DETW = PW + 2;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	req_type_t type_s1, type_s2, type_s3;

	logic signed [DW-1:0] adx_s1, ady_s1, bdx_s1, bdy_s1, cdx_s1, cdy_s1, ex_s1, ey_s1;

	logic signed [MW-1:0] bex_s2, bey_s2, aex_s2, aey_s2;
	logic signed [MW-1:0] adx2_s2, ady2_s2, bdx2_s2, bdy2_s2, cdx2_s2, cdy2_s2;
	logic signed [MW-1:0] bdxcdy_s2, bdycdx_s2, cdxady_s2, cdyadx_s2, adxbdy_s2, adybdx_s2;
	logic                 qr_eq_s2, pq_eq_s2;

	logic signed [SW-1:0] g_s3, h_s3;
	logic        [AW-1:0] al_s3, bl_s3, cl_s3;
	logic signed [MW-1:0] m1_s3, m2_s3, m3_s3;
	logic                 qr_eq_s3, pq_eq_s3;

	logic o_pos, o_neg, o_zero, fwd, g_nonneg, dot_ok, simple;
	logic simple_s4, simple_s5, simple_s6;
	logic circ_s4, circ_s5, circ_s6;

	logic signed [PW-1:0]   t1_s5, t2_s5, t3_s5;
	logic signed [DETW-1:0] det_s6;
	logic                   verdict_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: coordinate differences
	always_ff @(posedge clk) begin
		type_s1 <= req_type_t'(req_type);
		adx_s1  <= {q_x[W-1], q_x} - {p_x[W-1], p_x};
		ady_s1  <= {q_y[W-1], q_y} - {p_y[W-1], p_y};
		bdx_s1  <= {r_x[W-1], r_x} - {p_x[W-1], p_x};
		bdy_s1  <= {r_y[W-1], r_y} - {p_y[W-1], p_y};
		cdx_s1  <= {s_x[W-1], s_x} - {p_x[W-1], p_x};
		cdy_s1  <= {s_y[W-1], s_y} - {p_y[W-1], p_y};
		ex_s1   <= {r_x[W-1], r_x} - {q_x[W-1], q_x};
		ey_s1   <= {r_y[W-1], r_y} - {q_y[W-1], q_y};
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		type_s2   <= type_s1;
		bex_s2    <= bdx_s1 * ex_s1;
		bey_s2    <= bdy_s1 * ey_s1;
		aex_s2    <= adx_s1 * ex_s1;
		aey_s2    <= ady_s1 * ey_s1;
		adx2_s2   <= adx_s1 * adx_s1;
		ady2_s2   <= ady_s1 * ady_s1;
		bdx2_s2   <= bdx_s1 * bdx_s1;
		bdy2_s2   <= bdy_s1 * bdy_s1;
		cdx2_s2   <= cdx_s1 * cdx_s1;
		cdy2_s2   <= cdy_s1 * cdy_s1;
		bdxcdy_s2 <= bdx_s1 * cdy_s1;
		bdycdx_s2 <= bdy_s1 * cdx_s1;
		cdxady_s2 <= cdx_s1 * ady_s1;
		cdyadx_s2 <= cdy_s1 * adx_s1;
		adxbdy_s2 <= adx_s1 * bdy_s1;
		adybdx_s2 <= ady_s1 * bdx_s1;
		qr_eq_s2  <= (ex_s1 == '0) && (ey_s1 == '0);
		pq_eq_s2  <= (adx_s1 == '0) && (ady_s1 == '0);
	end

	// stage 3: sums. g = -(ahead dot), h = -(segment dot), m3 = orient(P,Q,R)
	always_ff @(posedge clk) begin
		type_s3  <= type_s2;
		g_s3     <= SW'(bex_s2) + SW'(bey_s2);
		h_s3     <= SW'(aex_s2) + SW'(aey_s2);
		al_s3    <= AW'(adx2_s2 + ady2_s2);
		bl_s3    <= AW'(bdx2_s2 + bdy2_s2);
		cl_s3    <= AW'(cdx2_s2 + cdy2_s2);
		m1_s3    <= bdxcdy_s2 - bdycdx_s2;
		m2_s3    <= cdxady_s2 - cdyadx_s2;
		m3_s3    <= adxbdy_s2 - adybdx_s2;
		qr_eq_s3 <= qr_eq_s2;
		pq_eq_s3 <= pq_eq_s2;
	end

	// stage 4: sign tests for everything but the in-circle case
	assign o_zero   = (m3_s3 == '0);
	assign o_neg    = m3_s3[MW-1];
	assign o_pos    = !o_neg && !o_zero;
	assign fwd      = g_s3[SW-1];
	assign g_nonneg = !g_s3[SW-1];
	assign dot_ok   = h_s3[SW-1] || (h_s3 == '0);

	always_comb begin
		unique case (type_s3)
			REQ_AHEAD:          simple = fwd;
			REQ_LEFT_OR_AHEAD:  simple = o_pos || (o_zero && fwd);
			REQ_RIGHT_OR_AHEAD: simple = o_neg || (o_zero && fwd);
			REQ_RIGHT_OF:       simple = o_neg;
			REQ_ON_SEGMENT:     simple = qr_eq_s3 ? pq_eq_s3 : (o_zero && dot_ok && g_nonneg);
			default:            simple = 1'b0;
		endcase
	end

	gpu_wide_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_a (
		.clk (clk),
		.a   (al_s3),
		.b   (m1_s3),
		.p   (t1_s5)
	);

	gpu_wide_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_b (
		.clk (clk),
		.a   (bl_s3),
		.b   (m2_s3),
		.p   (t2_s5)
	);

	gpu_wide_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_c (
		.clk (clk),
		.a   (cl_s3),
		.b   (m3_s3),
		.p   (t3_s5)
	);

	always_ff @(posedge clk) begin
		simple_s4 <= simple;
		circ_s4   <= (type_s3 == REQ_IN_CIRCLE);
		simple_s5 <= simple_s4;
		circ_s5   <= circ_s4;
		simple_s6 <= simple_s5;
		circ_s6   <= circ_s5;
		det_s6    <= DETW'(t1_s5) + DETW'(t2_s5) + DETW'(t3_s5);
	end

	always_ff @(posedge clk) begin
		verdict_s7 <= circ_s6 ? (!det_s6[DETW-1] && (det_s6 != '0)) : simple_s6;
	end

	assign busy    = 1'b0;
	assign done    = v_s7;
	assign verdict = verdict_s7;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("taken request produced no result");

	a_unknown_false: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type > REQ_IN_CIRCLE) |-> ##7 (done && !verdict))
		else $error("unknown selector gave a true verdict");

	a_endpoint_on_seg: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_ON_SEGMENT) && (p_x == q_x) && (p_y == q_y)
		|-> ##7 verdict)
		else $error("segment start not reported on segment");

	a_ahead_self: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_AHEAD) && (p_x == r_x) && (p_y == r_y)
		|-> ##7 !verdict)
		else $error("point at R reported ahead");

	a_circle_point: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_IN_CIRCLE) && (p_x == q_x) && (p_y == q_y)
		|-> ##7 !verdict)
		else $error("point on circle reported strictly inside");

endmodule
